// File: hdl/tsat_pkg.sv
// ----------------------------------------------------------------------------
// tsat_pkg
// Types and constants for the TCP client sequence/ack/window tracker.
// ----------------------------------------------------------------------------
package tsat_pkg;

   typedef enum logic [1:0] {
      OP_CONNECT = 2'd0,
      OP_SEND    = 2'd1,
      OP_RECEIVE = 2'd2,
      OP_RESET   = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_STALE       = 3'd1,
      ST_WINDOW_FULL = 3'd2,
      ST_INVALID     = 3'd3,
      ST_RESET_RX    = 3'd4,
      ST_OUT_OF_ORDER = 3'd5,
      ST_ACK_DECREASED = 3'd6,
      ST_OVER_ACKED  = 3'd7
   } status_type;

   typedef enum logic [2:0] {
      PH_OFFLINE    = 3'b001,
      PH_CONNECTING = 3'b010,
      PH_CONNECTED  = 3'b100
   } phase_type;

   localparam logic [1:0] CONN_OFFLINE    = 2'd0;
   localparam logic [1:0] CONN_CONNECTING = 2'd1;
   localparam logic [1:0] CONN_CONNECTED  = 2'd2;

   localparam logic [1:0] CSR_INIT_SEQUENCE = 2'd0;
   localparam logic [1:0] CSR_INIT_IP_IDENT = 2'd1;
   localparam logic [1:0] CSR_INIT_WINDOW   = 2'd2;

   localparam logic [7:0] FLAG_SYN = 8'h02;
   localparam logic [7:0] FLAG_RST = 8'h04;
   localparam logic [7:0] FLAG_ACK = 8'h10;

   localparam logic [3:0] MAX_SCALE = 4'd14;

   localparam logic [31:0] RST_INIT_SEQUENCE = 32'd0;
   localparam logic [15:0] RST_INIT_IP_IDENT = 16'd0;
   localparam logic [31:0] RST_INIT_WINDOW   = 32'd65535;

   typedef struct packed {
      opcode_type  opcode;
      logic [15:0] data_len;
      logic [7:0]  flags_byte;
      logic [31:0] seg_seq;
      logic [31:0] seg_ack;
      logic [15:0] seg_window;
      logic        seg_ok;
      logic        has_scale_option;
      logic [3:0]  scale_option;
   } item_type;

   typedef struct packed {
      logic        tx_send;
      logic [7:0]  tx_flags;
      logic [31:0] tx_seq;
      logic [31:0] tx_ack;
      logic [15:0] tx_ip_ident;
      logic [15:0] tx_length;
      logic        tx_with_options;
      status_type  status;
      logic [1:0]  conn_state;
   } result_type;

   typedef struct packed {
      phase_type   phase;
      logic [31:0] send_next;
      logic [31:0] recv_expected;
      logic [15:0] ip_ident;
      logic [31:0] last_acked;
      logic [31:0] outstanding_bytes;
      logic [31:0] send_window;
      logic [3:0]  peer_scale;
   } track_type;

   typedef struct packed {
      logic        valid;
      logic [1:0]  index;
      logic [31:0] data;
   } csr_wr_type;

   function automatic logic [1:0] phase_code(input phase_type ph);
      logic [1:0] code;
      case (ph)
         PH_OFFLINE:    code = CONN_OFFLINE;
         PH_CONNECTING: code = CONN_CONNECTING;
         PH_CONNECTED:  code = CONN_CONNECTED;
         default:       code = CONN_OFFLINE;
      endcase
      return code;
   endfunction

endpackage

// File: hdl/tsat_if.sv
// ----------------------------------------------------------------------------
// tsat_if
// Valid/ready channel interfaces: event items, result items, register writes.
// ----------------------------------------------------------------------------
interface tsat_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [15:0] data_len;
   logic [7:0]  flags_byte;
   logic [31:0] seg_seq;
   logic [31:0] seg_ack;
   logic [15:0] seg_window;
   logic        seg_ok;
   logic        has_scale_option;
   logic [3:0]  scale_option;

   modport source (
      output valid, opcode, data_len, flags_byte, seg_seq, seg_ack, seg_window,
             seg_ok, has_scale_option, scale_option,
      input  ready
   );
   modport sink (
      input  valid, opcode, data_len, flags_byte, seg_seq, seg_ack, seg_window,
             seg_ok, has_scale_option, scale_option,
      output ready
   );
endinterface

interface tsat_rsp_if;
   logic        valid;
   logic        ready;
   logic        tx_send;
   logic [7:0]  tx_flags;
   logic [31:0] tx_seq;
   logic [31:0] tx_ack;
   logic [15:0] tx_ip_ident;
   logic [15:0] tx_length;
   logic        tx_with_options;
   logic [2:0]  status;
   logic [1:0]  conn_state;

   modport source (
      output valid, tx_send, tx_flags, tx_seq, tx_ack, tx_ip_ident, tx_length,
             tx_with_options, status, conn_state,
      input  ready
   );
   modport sink (
      input  valid, tx_send, tx_flags, tx_seq, tx_ack, tx_ip_ident, tx_length,
             tx_with_options, status, conn_state,
      output ready
   );
endinterface

interface tsat_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/tsat_step.sv
// ----------------------------------------------------------------------------
// tsat_step
// Combinational event handler: next tracker state and the result item.
// ----------------------------------------------------------------------------
module tsat_step (
   input  tsat_pkg::item_type   item,
   input  tsat_pkg::track_type  cur,
   output tsat_pkg::track_type  nxt,
   output tsat_pkg::result_type res
);

   logic [31:0]          plen_ext;
   logic [31:0]          ack_delta;
   logic [31:0]          rwnd;
   logic                 synced;
   tsat_pkg::track_type  rx;
   tsat_pkg::status_type status;

   assign plen_ext  = {16'd0, item.data_len};
   assign ack_delta = item.seg_ack - cur.last_acked;
   assign rwnd      = {16'd0, item.seg_window} << cur.peer_scale;
   assign synced    = (cur.recv_expected != 32'd0);

   // state after window update and ack accounting
   always_comb begin
      rx = cur;
      if (rwnd != 32'd0) begin
         rx.send_window = rwnd;
      end
      rx.outstanding_bytes = cur.outstanding_bytes - ack_delta;
      rx.last_acked        = item.seg_ack;
   end

   always_comb begin
      nxt    = cur;
      res    = '0;
      status = tsat_pkg::ST_OK;
      case (item.opcode)
         tsat_pkg::OP_CONNECT: begin
            if (cur.outstanding_bytes <= cur.send_window) begin
               res.tx_send           = 1'b1;
               res.tx_flags          = tsat_pkg::FLAG_SYN;
               res.tx_seq            = cur.send_next;
               res.tx_ack            = cur.recv_expected;
               res.tx_ip_ident       = cur.ip_ident;
               res.tx_with_options   = 1'b1;
               nxt.phase             = tsat_pkg::PH_CONNECTING;
               nxt.ip_ident          = cur.ip_ident + 16'd1;
               nxt.outstanding_bytes = 32'd1;
            end else begin
               status = tsat_pkg::ST_WINDOW_FULL;
            end
         end
         tsat_pkg::OP_SEND: begin
            if ({1'b0, cur.outstanding_bytes} + {1'b0, plen_ext}
                  <= {1'b0, cur.send_window}) begin
               res.tx_send           = 1'b1;
               res.tx_flags          = item.flags_byte;
               res.tx_seq            = cur.send_next;
               res.tx_ack            = cur.recv_expected;
               res.tx_ip_ident       = cur.ip_ident;
               res.tx_length         = item.data_len;
               nxt.ip_ident          = cur.ip_ident + 16'd1;
               nxt.send_next         = cur.send_next + plen_ext;
               nxt.outstanding_bytes = cur.outstanding_bytes + plen_ext;
            end else begin
               status = tsat_pkg::ST_WINDOW_FULL;
            end
         end
         tsat_pkg::OP_RESET: begin
            if (cur.outstanding_bytes <= cur.send_window) begin
               res.tx_send     = 1'b1;
               res.tx_flags    = tsat_pkg::FLAG_RST;
               res.tx_seq      = cur.send_next;
               res.tx_ack      = cur.recv_expected;
               res.tx_ip_ident = cur.ip_ident;
               nxt.phase       = tsat_pkg::PH_OFFLINE;
               nxt.ip_ident    = cur.ip_ident + 16'd1;
            end else begin
               status = tsat_pkg::ST_WINDOW_FULL;
            end
         end
         tsat_pkg::OP_RECEIVE: begin
            if (!item.seg_ok) begin
               status = tsat_pkg::ST_INVALID;
            end else if ((item.flags_byte & tsat_pkg::FLAG_RST) != 8'd0) begin
               status = tsat_pkg::ST_RESET_RX;
            end else if (synced && (item.seg_seq < cur.recv_expected)) begin
               status = tsat_pkg::ST_STALE;
            end else if (synced && (item.seg_seq != cur.recv_expected)) begin
               status = tsat_pkg::ST_OUT_OF_ORDER;
            end else if (item.seg_ack < cur.last_acked) begin
               status = tsat_pkg::ST_ACK_DECREASED;
            end else if (ack_delta > cur.outstanding_bytes) begin
               status = tsat_pkg::ST_OVER_ACKED;
            end else if ((cur.phase == tsat_pkg::PH_CONNECTING) &&
                         (item.flags_byte == (tsat_pkg::FLAG_SYN | tsat_pkg::FLAG_ACK))) begin
               if (rx.outstanding_bytes <= rx.send_window) begin
                  res.tx_send       = 1'b1;
                  res.tx_flags      = tsat_pkg::FLAG_ACK;
                  res.tx_seq        = cur.send_next + 32'd1;
                  res.tx_ack        = item.seg_seq + 32'd1;
                  res.tx_ip_ident   = cur.ip_ident;
                  nxt               = rx;
                  nxt.phase         = tsat_pkg::PH_CONNECTED;
                  nxt.recv_expected = item.seg_seq + 32'd1;
                  nxt.send_next     = cur.send_next + 32'd1;
                  nxt.ip_ident      = cur.ip_ident + 16'd1;
                  if (item.has_scale_option) begin
                     nxt.peer_scale = (item.scale_option > tsat_pkg::MAX_SCALE) ?
                                      tsat_pkg::MAX_SCALE : item.scale_option;
                  end
               end else begin
                  status = tsat_pkg::ST_WINDOW_FULL;
               end
            end else if ((cur.phase == tsat_pkg::PH_CONNECTED) &&
                         (item.data_len != 16'd0)) begin
               if (rx.outstanding_bytes <= rx.send_window) begin
                  res.tx_send       = 1'b1;
                  res.tx_flags      = tsat_pkg::FLAG_ACK;
                  res.tx_seq        = cur.send_next;
                  res.tx_ack        = item.seg_seq + plen_ext;
                  res.tx_ip_ident   = cur.ip_ident;
                  nxt               = rx;
                  nxt.recv_expected = item.seg_seq + plen_ext;
                  nxt.ip_ident      = cur.ip_ident + 16'd1;
               end else begin
                  status = tsat_pkg::ST_WINDOW_FULL;
               end
            end else begin
               nxt = rx;
            end
         end
         default: begin
            status = tsat_pkg::ST_INVALID;
         end
      endcase
      if (status != tsat_pkg::ST_OK) begin
         nxt = cur;
         res = '0;
      end
      res.status     = status;
      res.conn_state = tsat_pkg::phase_code(nxt.phase);
   end

endmodule

// File: hdl/tsat_state.sv
// ----------------------------------------------------------------------------
// tsat_state
// Connection state registers; loaded by register writes and committed events.
// ----------------------------------------------------------------------------
module tsat_state (
   input  logic                   clock,
   input  logic                   reset,
   input  tsat_pkg::csr_wr_type   csr_wr,
   input  logic                   commit,
   input  tsat_pkg::track_type    nxt,
   output tsat_pkg::track_type    cur
);

   tsat_pkg::track_type track_ff;
   tsat_pkg::track_type track_in;

   always_comb begin
      track_in = track_ff;
      if (commit) begin
         track_in = nxt;
      end
      if (csr_wr.valid) begin
         case (csr_wr.index)
            tsat_pkg::CSR_INIT_SEQUENCE: begin
               track_in.send_next  = csr_wr.data;
               track_in.last_acked = csr_wr.data;
            end
            tsat_pkg::CSR_INIT_IP_IDENT: begin
               track_in.ip_ident = csr_wr.data[15:0];
            end
            tsat_pkg::CSR_INIT_WINDOW: begin
               track_in.send_window = csr_wr.data;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         track_ff.phase             <= tsat_pkg::PH_OFFLINE;
         track_ff.send_next         <= tsat_pkg::RST_INIT_SEQUENCE;
         track_ff.recv_expected     <= 32'd0;
         track_ff.ip_ident          <= tsat_pkg::RST_INIT_IP_IDENT;
         track_ff.last_acked        <= tsat_pkg::RST_INIT_SEQUENCE;
         track_ff.outstanding_bytes <= 32'd0;
         track_ff.send_window       <= tsat_pkg::RST_INIT_WINDOW;
         track_ff.peer_scale        <= 4'd0;
      end else begin
         track_ff <= track_in;
      end
   end

   assign cur = track_ff;

endmodule

// File: hdl/tcp_client_seq_ack_tracker_core.sv
// ----------------------------------------------------------------------------
// tcp_client_seq_ack_tracker_core
// TCP client endpoint tracker: sequence, ack, window and connection phase.
// Each accepted item is held in the input register; its result goes to the result register.
// Throughput: 1 item per cycle while the result side is not stalled; the next state is computed combinationally.
// Input and result registers decouple the two sides under backpressure.
// Reset clears both stages and loads the state with the register defaults.
// ----------------------------------------------------------------------------
module tcp_client_seq_ack_tracker_core (
   input logic        clock,
   input logic        reset,
   tsat_req_if.sink   req_chan,
   tsat_rsp_if.source rsp_chan,
   tsat_csr_if.sink   csr_chan
);

   tsat_pkg::item_type   item_ff;
   tsat_pkg::item_type   item_in;
   logic                 item_vld_ff;
   logic                 item_vld_in;
   tsat_pkg::result_type rsp_ff;
   tsat_pkg::result_type rsp_in;
   logic                 rsp_vld_ff;
   logic                 rsp_vld_in;
   logic                 advance;
   tsat_pkg::track_type  cur;
   tsat_pkg::track_type  nxt;
   tsat_pkg::result_type res;
   tsat_pkg::csr_wr_type csr_wr;

   assign advance        = item_vld_ff && (!rsp_vld_ff || rsp_chan.ready);
   assign req_chan.ready = !item_vld_ff || advance;
   assign csr_chan.ready = 1'b1;

   assign csr_wr.valid = csr_chan.valid;
   assign csr_wr.index = csr_chan.index;
   assign csr_wr.data  = csr_chan.data;

   always_comb begin
      item_in.opcode           = tsat_pkg::opcode_type'(req_chan.opcode);
      item_in.data_len         = req_chan.data_len;
      item_in.flags_byte       = req_chan.flags_byte;
      item_in.seg_seq          = req_chan.seg_seq;
      item_in.seg_ack          = req_chan.seg_ack;
      item_in.seg_window       = req_chan.seg_window;
      item_in.seg_ok           = req_chan.seg_ok;
      item_in.has_scale_option = req_chan.has_scale_option;
      item_in.scale_option     = req_chan.scale_option;
   end

   always_comb begin
      item_vld_in = item_vld_ff;
      if (req_chan.ready) begin
         item_vld_in = req_chan.valid;
      end
      rsp_vld_in = rsp_vld_ff;
      if (advance) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_vld_in = 1'b0;
      end
      rsp_in = res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         item_vld_ff <= item_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         item_ff <= item_in;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   tsat_step u_step (
      .item (item_ff),
      .cur  (cur),
      .nxt  (nxt),
      .res  (res)
   );

   tsat_state u_state (
      .clock  (clock),
      .reset  (reset),
      .csr_wr (csr_wr),
      .commit (advance),
      .nxt    (nxt),
      .cur    (cur)
   );

   assign rsp_chan.valid           = rsp_vld_ff;
   assign rsp_chan.tx_send         = rsp_ff.tx_send;
   assign rsp_chan.tx_flags        = rsp_ff.tx_flags;
   assign rsp_chan.tx_seq          = rsp_ff.tx_seq;
   assign rsp_chan.tx_ack          = rsp_ff.tx_ack;
   assign rsp_chan.tx_ip_ident     = rsp_ff.tx_ip_ident;
   assign rsp_chan.tx_length       = rsp_ff.tx_length;
   assign rsp_chan.tx_with_options = rsp_ff.tx_with_options;
   assign rsp_chan.status          = rsp_ff.status;
   assign rsp_chan.conn_state      = rsp_ff.conn_state;

endmodule

// File: hdl/tsat_checker.sv
// ----------------------------------------------------------------------------
// tsat_checker
// Port-level assertions for the tracker core, attached by bind.
// ----------------------------------------------------------------------------
module tsat_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        tx_send,
   input logic [7:0]  tx_flags,
   input logic [31:0] tx_seq,
   input logic [31:0] tx_ack,
   input logic [15:0] tx_ip_ident,
   input logic [15:0] tx_length,
   input logic        tx_with_options,
   input logic [2:0]  status,
   input logic [1:0]  conn_state
);

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(tx_seq))
      else $error("stalled result changed");

   a_fail_no_tx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status != tsat_pkg::ST_OK) |->
         !tx_send && (tx_flags == 8'd0) && (tx_seq == 32'd0) && (tx_ack == 32'd0) &&
         (tx_ip_ident == 16'd0) && (tx_length == 16'd0))
      else $error("failed event carries a segment");

   a_syn_options: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && tx_with_options |->
         tx_send && (tx_flags == tsat_pkg::FLAG_SYN) && (tx_length == 16'd0) &&
         (conn_state == tsat_pkg::CONN_CONNECTING))
      else $error("options on a segment other than the connect SYN");

endmodule

bind tcp_client_seq_ack_tracker_core tsat_checker u_tsat_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .tx_send         (rsp_chan.tx_send),
   .tx_flags        (rsp_chan.tx_flags),
   .tx_seq          (rsp_chan.tx_seq),
   .tx_ack          (rsp_chan.tx_ack),
   .tx_ip_ident     (rsp_chan.tx_ip_ident),
   .tx_length       (rsp_chan.tx_length),
   .tx_with_options (rsp_chan.tx_with_options),
   .status          (rsp_chan.status),
   .conn_state      (rsp_chan.conn_state)
);
